>>> src/chacha20_stream_cipher_unit_macros.svh
// assertion helpers for the stream cipher unit
`ifndef CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTH
// plain property, checked at every edge out of reset
`define CC20_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define CC20_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CC20_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CC20_ASSERT(label, clk, rst_n, prop, msg)
`define CC20_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define CC20_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/cc20_pkg.sv
`default_nettype none
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] block_t;
	typedef logic [3:0][31:0] quad_t;
	typedef logic [3:0] step_t;

	localparam word_t SIGMA0 = 32'h6170_7865;
	localparam word_t SIGMA1 = 32'h3320_646e;
	localparam word_t SIGMA2 = 32'h7962_2d32;
	localparam word_t SIGMA3 = 32'h6b20_6574;

	localparam int BLOCK_BYTES = 64;
	localparam int POS_W = $clog2(BLOCK_BYTES);
	localparam int DOUBLE_ROUNDS = 10;
	localparam logic [3:0] LAST_ROUND = 4'(DOUBLE_ROUNDS - 1);
	localparam logic [3:0] LAST_WORD = 4'd15;

	// register map, one 64-bit slot per register
	typedef enum logic [2:0] {
		REG_KEY0,
		REG_KEY1,
		REG_KEY2,
		REG_KEY3,
		REG_NONCE_LO,
		REG_NONCE_HI,
		REG_START
	} reg_idx_t;

	// microcode
	typedef enum logic [2:0] {
		OP_NOP,
		OP_TAKE,
		OP_LOAD,
		OP_HALF_A,
		OP_HALF_B,
		OP_FEED,
		OP_READ,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_BLOCK_OK,
		C_ROUNDS_LEFT,
		C_FEED_LEFT
	} cond_t;

	typedef struct packed {
		op_t   op;
		logic  diag;
		cond_t cond;
		step_t target;
	} ucode_t;

	localparam step_t STEP_TAKE   = 4'd0;
	localparam step_t STEP_LOAD   = 4'd1;
	localparam step_t STEP_COL_A  = 4'd2;
	localparam step_t STEP_COL_B  = 4'd3;
	localparam step_t STEP_DIAG_A = 4'd4;
	localparam step_t STEP_DIAG_B = 4'd5;
	localparam step_t STEP_FEED   = 4'd6;
	localparam step_t STEP_READ   = 4'd7;
	localparam step_t STEP_EMIT   = 4'd8;

	// control between sequencer and round datapath
	typedef struct packed {
		logic load;
		logic rnd;
		logic second;
		logic diag;
		logic feed;
	} core_ctl_t;

	typedef struct packed {
		logic       en;
		logic [3:0] addr;
		word_t      data;
	} ks_wr_t;

	function automatic ucode_t ucode_rom(step_t pc);
		ucode_t cw;
		unique case (pc)
			STEP_TAKE:   cw = '{OP_TAKE,   1'b0, C_BLOCK_OK,    STEP_EMIT};
			STEP_LOAD:   cw = '{OP_LOAD,   1'b0, C_NEXT,        STEP_TAKE};
			STEP_COL_A:  cw = '{OP_HALF_A, 1'b0, C_NEXT,        STEP_TAKE};
			STEP_COL_B:  cw = '{OP_HALF_B, 1'b0, C_NEXT,        STEP_TAKE};
			STEP_DIAG_A: cw = '{OP_HALF_A, 1'b1, C_NEXT,        STEP_TAKE};
			STEP_DIAG_B: cw = '{OP_HALF_B, 1'b1, C_ROUNDS_LEFT, STEP_COL_A};
			STEP_FEED:   cw = '{OP_FEED,   1'b0, C_FEED_LEFT,   STEP_FEED};
			STEP_READ:   cw = '{OP_READ,   1'b0, C_NEXT,        STEP_TAKE};
			STEP_EMIT:   cw = '{OP_EMIT,   1'b0, C_ALWAYS,      STEP_TAKE};
			default:     cw = '{OP_NOP,    1'b0, C_ALWAYS,      STEP_TAKE};
		endcase
		return cw;
	endfunction

	function automatic word_t rotl(word_t v, int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// half a quarter round; q[0]..q[3] = a, b, c, d
	function automatic quad_t half_qr(quad_t q, logic second);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		a = q[0];
		b = q[1];
		c = q[2];
		d = q[3];
		a = a + b;
		d = d ^ a;
		d = second ? rotl(d, 8) : rotl(d, 16);
		c = c + d;
		b = b ^ c;
		b = second ? rotl(b, 7) : rotl(b, 12);
		return {d, c, b, a};
	endfunction

endpackage
`default_nettype wire

>>> src/cc20_if.sv
`default_nettype none
interface cc20_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_message;

	modport source(output valid, output data_byte, output first_of_message, input ready);
	modport sink(input valid, input data_byte, input first_of_message, output ready);
endinterface

interface cc20_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;

	modport source(output valid, output out_byte, input ready);
	modport sink(input valid, input out_byte, output ready);
endinterface
`default_nettype wire

>>> src/cc20_core.sv
`default_nettype none
module cc20_core import cc20_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  core_ctl_t ctl,
	input  block_t    init,
	output ks_wr_t    wr
);

	block_t     words_q;
	block_t     words_nxt;
	logic [3:0] feed_idx_q;

	// four lanes, column or diagonal grouping
	always_comb begin
		logic [1:0] jj;
		logic [1:0] s1;
		logic [1:0] s2;
		logic [1:0] s3;
		logic [3:0] ia;
		logic [3:0] ib;
		logic [3:0] ic;
		logic [3:0] id;
		quad_t      lane_in;
		quad_t      lane_out;
		words_nxt = words_q;
		s1 = {1'b0, ctl.diag};
		s2 = {ctl.diag, 1'b0};
		s3 = {ctl.diag, ctl.diag};
		for (int j = 0; j < 4; j++) begin
			jj = 2'(j);
			ia = {2'b00, jj};
			ib = {2'b01, 2'(jj + s1)};
			ic = {2'b10, 2'(jj + s2)};
			id = {2'b11, 2'(jj + s3)};
			lane_in = {words_q[id], words_q[ic], words_q[ib], words_q[ia]};
			lane_out = half_qr(lane_in, ctl.second);
			words_nxt[ia] = lane_out[0];
			words_nxt[ib] = lane_out[1];
			words_nxt[ic] = lane_out[2];
			words_nxt[id] = lane_out[3];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			words_q <= init;
		end else if (ctl.rnd) begin
			words_q <= words_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_idx_q <= '0;
		end else if (ctl.load) begin
			feed_idx_q <= '0;
		end else if (ctl.feed) begin
			feed_idx_q <= feed_idx_q + 4'd1;
		end
	end

	// feed-forward, one word per step
	assign wr.en   = ctl.feed;
	assign wr.addr = feed_idx_q;
	assign wr.data = words_q[feed_idx_q] + init[feed_idx_q];

endmodule
`default_nettype wire

>>> src/chacha20_stream_cipher_unit.sv
// ChaCha20 (RFC 8439, 96-bit nonce, 32-bit block counter) byte stream unit. Each request
// carries one byte and a first-of-message flag; each response is that byte XOR the next
// keystream byte, so the same unit encrypts and decrypts. Key, nonce and start counter are
// written over the APB port (64-bit slots at byte addresses 0x00..0x30: key words 0..3,
// nonce low, nonce high, start counter); the user must do this only while no request is
// in flight, the block does not enforce it. A flagged byte restarts at the start counter
// and keystream byte 0, and the counter steps by one per 64 bytes, wrapping at 2^32.
// Control is a nine-step microprogram: a byte inside a held block is a take step, then an
// output step. A byte that needs a new block runs a take, one load, 40 half-quarter-round
// steps of a four-lane round unit (20 rounds), 16 feed-forward writes through the single
// write port of the 16-word keystream RAM, one RAM read and the output step, one byte at
// a time. A full response register holds the output step until it is taken.
`default_nettype none
`include "chacha20_stream_cipher_unit_macros.svh"
module chacha20_stream_cipher_unit import cc20_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	cc20_req_if.sink    req,
	cc20_rsp_if.source  rsp
);

	// configuration registers
	logic [63:0] key0_q;
	logic [63:0] key1_q;
	logic [63:0] key2_q;
	logic [63:0] key3_q;
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;
	logic [31:0] start_q;

	// sequencer
	step_t      pc_q;
	step_t      pc_d;
	ucode_t     cw;
	logic       stall;
	logic       cond_true;
	logic       take_fire;
	logic       emit_fire;
	logic       blk_ok;

	// stream state
	logic [POS_W-1:0] pos_q;
	logic [31:0]      blk_cnt_q;
	logic             blk_ready_q;
	logic [3:0]       rnd_q;
	logic [7:0]       data_q;

	// keystream ram, one 32-bit word per four bytes
	word_t      ks_mem [16];
	word_t      ks_rd_q;
	logic       rd_en;
	logic [3:0] rd_addr;

	logic [7:0] rsp_data_q;
	logic       rsp_valid_q;

	block_t    init_words;
	core_ctl_t core_ctl;
	ks_wr_t    ks_wr;

	// apb register file, writes complete in the access phase
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			start_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_KEY0:     key0_q     <= pwdata;
				REG_KEY1:     key1_q     <= pwdata;
				REG_KEY2:     key2_q     <= pwdata;
				REG_KEY3:     key3_q     <= pwdata;
				REG_NONCE_LO: nonce_lo_q <= pwdata;
				REG_NONCE_HI: nonce_hi_q <= pwdata[31:0];
				REG_START:    start_q    <= pwdata[31:0];
				default: ;    // unmapped slot, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_KEY0:     prdata = key0_q;
			REG_KEY1:     prdata = key1_q;
			REG_KEY2:     prdata = key2_q;
			REG_KEY3:     prdata = key3_q;
			REG_NONCE_LO: prdata = nonce_lo_q;
			REG_NONCE_HI: prdata = {32'd0, nonce_hi_q};
			REG_START:    prdata = {32'd0, start_q};
			default:      prdata = '0;
		endcase
	end

	// initial block state: constants, key, counter, nonce
	always_comb begin
		init_words[0]  = SIGMA0;
		init_words[1]  = SIGMA1;
		init_words[2]  = SIGMA2;
		init_words[3]  = SIGMA3;
		init_words[4]  = key0_q[31:0];
		init_words[5]  = key0_q[63:32];
		init_words[6]  = key1_q[31:0];
		init_words[7]  = key1_q[63:32];
		init_words[8]  = key2_q[31:0];
		init_words[9]  = key2_q[63:32];
		init_words[10] = key3_q[31:0];
		init_words[11] = key3_q[63:32];
		init_words[12] = blk_cnt_q;
		init_words[13] = nonce_lo_q[31:0];
		init_words[14] = nonce_lo_q[63:32];
		init_words[15] = nonce_hi_q;
	end

	// microprogram fetch and step control
	assign cw        = ucode_rom(pc_q);
	assign req.ready = (cw.op == OP_TAKE);
	assign take_fire = req.valid && req.ready;
	// a flagged byte always needs a fresh block
	assign blk_ok    = blk_ready_q && !req.first_of_message;

	always_comb begin
		stall = 1'b0;
		if (cw.op == OP_TAKE) begin
			stall = !req.valid;
		end else if (cw.op == OP_EMIT) begin
			stall = rsp_valid_q && !rsp.ready;
		end
	end

	assign emit_fire = (cw.op == OP_EMIT) && !stall;

	always_comb begin
		unique case (cw.cond)
			C_NEXT:        cond_true = 1'b0;
			C_ALWAYS:      cond_true = 1'b1;
			C_BLOCK_OK:    cond_true = blk_ok;
			C_ROUNDS_LEFT: cond_true = (rnd_q != LAST_ROUND);
			C_FEED_LEFT:   cond_true = (ks_wr.addr != LAST_WORD);
			default:       cond_true = 1'b0;
		endcase
	end

	always_comb begin
		priority if (stall) begin
			pc_d = pc_q;
		end else if (cond_true) begin
			pc_d = cw.target;
		end else begin
			pc_d = pc_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_TAKE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// round datapath
	assign core_ctl.load   = (cw.op == OP_LOAD);
	assign core_ctl.rnd    = (cw.op == OP_HALF_A) || (cw.op == OP_HALF_B);
	assign core_ctl.second = (cw.op == OP_HALF_B);
	assign core_ctl.diag   = cw.diag;
	assign core_ctl.feed   = (cw.op == OP_FEED);

	cc20_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.init   (init_words),
		.wr     (ks_wr)
	);

	// double-round count, closes after the diagonal second half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (cw.op == OP_LOAD) begin
			rnd_q <= '0;
		end else if (cw.op == OP_HALF_B && cw.diag) begin
			rnd_q <= (rnd_q == LAST_ROUND) ? 4'd0 : rnd_q + 4'd1;
		end
	end

	// stream position, block counter and block-held flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			blk_cnt_q   <= '0;
			blk_ready_q <= 1'b0;
		end else begin
			priority if (take_fire) begin
				if (req.first_of_message) begin
					pos_q       <= '0;
					blk_cnt_q   <= start_q;
					blk_ready_q <= 1'b0;
				end
			end else if (ks_wr.en && ks_wr.addr == LAST_WORD) begin
				blk_cnt_q   <= blk_cnt_q + 32'd1;
				blk_ready_q <= 1'b1;
			end else if (emit_fire) begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q == POS_W'(BLOCK_BYTES - 1)) begin
					blk_ready_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_fire) begin
			data_q <= req.data_byte;
		end
	end

	// keystream ram: written during feed-forward, read on take or after a new block
	assign rd_en   = take_fire || (cw.op == OP_READ);
	assign rd_addr = (take_fire && req.first_of_message) ? 4'd0 : pos_q[POS_W-1:2];

	always_ff @(posedge clk) begin
		if (ks_wr.en) begin
			ks_mem[ks_wr.addr] <= ks_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ks_rd_q <= ks_mem[rd_addr];
		end
	end

	// response register, little-endian byte pick from the word
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			rsp_data_q <= data_q ^ 8'(ks_rd_q >> {pos_q[1:0], 3'b000});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.out_byte = rsp_data_q;

	`CC20_ASSERT(a_rnd_range, clk, arst_n, rnd_q <= LAST_ROUND, "double-round count overran")
	`CC20_ASSERT_SAME(a_emit_free, clk, arst_n, emit_fire, !rsp_valid_q || rsp.ready, "response overwritten")
	`CC20_ASSERT_SAME(a_cnt_step, clk, arst_n, $rose(blk_ready_q), blk_cnt_q == $past(blk_cnt_q) + 32'd1, "counter not stepped with new block")
	`CC20_ASSERT_NEXT(a_held_path, clk, arst_n, take_fire && blk_ok, pc_q == STEP_EMIT, "held block byte did not go to output")

endmodule
`default_nettype wire

>>> tb/chacha20_stream_checker.sv
`timescale 1ns / 100ps
module chacha20_stream_checker import cc20_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic [63:0] prdata,
	input  logic        pready,
	cc20_req_if         req_mon,
	cc20_rsp_if         rsp_mon,
	output int          mismatches,
	output int          bytes_in_flight
);

	// shadow of the register file
	logic [63:0] key_words [4];
	logic [63:0] nonce_lo;
	logic [31:0] nonce_hi;
	logic [31:0] start_ctr;

	// keystream position
	logic [511:0] ks_bits;
	logic [5:0]   byte_pos;
	logic [31:0]  blk_ctr;
	logic         have_block;

	logic [7:0] expected_cipher_bytes [$];
	logic [7:0] oldest_cipher_byte;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		mismatches = mismatches + 1;
	endtask

	function automatic logic [31:0] rol32(logic [31:0] x, int n);
		logic [63:0] t;
		t = {x, x} >> (32 - n);
		return t[31:0];
	endfunction

	function automatic logic [15:0][31:0] quarter_mix(logic [15:0][31:0] w,
			int a, int b, int c, int d);
		w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
		w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
		w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
		w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
		return w;
	endfunction

	// 64 keystream bytes, byte i at bits 8*i
	function automatic logic [511:0] keystream_block_for(logic [31:0] ctr);
		logic [15:0][31:0] init_w;
		logic [15:0][31:0] w;
		logic [511:0] ks;
		init_w[0] = SIGMA0;
		init_w[1] = SIGMA1;
		init_w[2] = SIGMA2;
		init_w[3] = SIGMA3;
		for (int k = 0; k < 4; k++) begin
			init_w[4 + 2 * k] = key_words[k][31:0];
			init_w[5 + 2 * k] = key_words[k][63:32];
		end
		init_w[12] = ctr;
		init_w[13] = nonce_lo[31:0];
		init_w[14] = nonce_lo[63:32];
		init_w[15] = nonce_hi;
		w = init_w;
		for (int r = 0; r < 10; r++) begin
			w = quarter_mix(w, 0, 4, 8, 12);
			w = quarter_mix(w, 1, 5, 9, 13);
			w = quarter_mix(w, 2, 6, 10, 14);
			w = quarter_mix(w, 3, 7, 11, 15);
			w = quarter_mix(w, 0, 5, 10, 15);
			w = quarter_mix(w, 1, 6, 11, 12);
			w = quarter_mix(w, 2, 7, 8, 13);
			w = quarter_mix(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			ks[32 * i +: 32] = w[i] + init_w[i];
		return ks;
	endfunction

	function automatic logic [7:0] predict_cipher_byte(logic [7:0] data, logic first);
		logic [7:0] result;
		if (first) begin
			blk_ctr = start_ctr;
			byte_pos = '0;
			have_block = 1'b0;
		end
		if (!have_block) begin
			ks_bits = keystream_block_for(blk_ctr);
			blk_ctr = blk_ctr + 32'd1;
			have_block = 1'b1;
		end
		result = data ^ ks_bits[8 * byte_pos +: 8];
		byte_pos = byte_pos + 6'd1;
		if (byte_pos == '0)
			have_block = 1'b0;
		return result;
	endfunction

	function automatic logic [63:0] register_value(logic [2:0] slot);
		case (slot)
			REG_KEY0:     return key_words[0];
			REG_KEY1:     return key_words[1];
			REG_KEY2:     return key_words[2];
			REG_KEY3:     return key_words[3];
			REG_NONCE_LO: return nonce_lo;
			REG_NONCE_HI: return {32'd0, nonce_hi};
			REG_START:    return {32'd0, start_ctr};
			default:      return '0;
		endcase
	endfunction

	task automatic store_register(logic [2:0] slot, logic [63:0] value);
		case (slot)
			REG_KEY0:     key_words[0] = value;
			REG_KEY1:     key_words[1] = value;
			REG_KEY2:     key_words[2] = value;
			REG_KEY3:     key_words[3] = value;
			REG_NONCE_LO: nonce_lo = value;
			REG_NONCE_HI: nonce_hi = value[31:0];
			REG_START:    start_ctr = value[31:0];
			default:      ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++)
				key_words[k] = '0;
			nonce_lo = '0;
			nonce_hi = '0;
			start_ctr = '0;
			ks_bits = '0;
			byte_pos = '0;
			blk_ctr = '0;
			have_block = 1'b0;
			expected_cipher_bytes.delete();
			mismatches = 0;
			bytes_in_flight <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite)
					store_register(paddr[5:3], pwdata);
				else if (prdata !== register_value(paddr[5:3]))
					report_mismatch("register read", prdata, register_value(paddr[5:3]));
			end
			if (req_mon.valid && req_mon.ready)
				expected_cipher_bytes.push_back(
					predict_cipher_byte(req_mon.data_byte, req_mon.first_of_message));
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_cipher_bytes.size() == 0) begin
					report_mismatch("unexpected response", rsp_mon.out_byte, '0);
				end else begin
					oldest_cipher_byte = expected_cipher_bytes.pop_front();
					if (rsp_mon.out_byte !== oldest_cipher_byte)
						report_mismatch("out_byte", rsp_mon.out_byte, oldest_cipher_byte);
				end
			end
			bytes_in_flight <= expected_cipher_bytes.size();
		end
	end

endmodule

>>> tb/chacha20_stream_cipher_unit_tb.sv
`timescale 1ns / 100ps
module chacha20_stream_cipher_unit_tb import cc20_pkg::*; ();

	// sized by a byte that needs a fresh block, sets the final settle wait
	localparam int BLOCK_MAKE_CYCLES = 60;
	localparam int RANDOM_BYTES = 1550;
	// no idling once this few random bytes remain
	localparam int CALM_TAIL_BYTES = 250;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int LONG_HOLD_AFTER = 600;
	// register slot past the end of the map, writes must be dropped
	localparam logic [2:0] UNUSED_SLOT = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	int mismatches;
	int bytes_in_flight;
	int bytes_sent = 0;
	int random_start = 0;
	bit req_idle_on = 1'b0;
	bit rsp_idle_on = 1'b0;
	bit long_hold_done = 1'b0;

	cc20_req_if req();
	cc20_rsp_if rsp();

	chacha20_stream_cipher_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.rsp     (rsp)
	);

	chacha20_stream_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.req_mon         (req),
		.rsp_mon         (rsp),
		.mismatches      (mismatches),
		.bytes_in_flight (bytes_in_flight)
	);

	always #2 clk = ~clk;

	// hard stop in case a response never shows up
	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	// response side: short random stalls, one long hold-off to back the block up
	initial begin
		rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && bytes_sent >= LONG_HOLD_AFTER && req.valid) begin
				long_hold_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				rsp.ready <= 1'b1;
			end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// one register access: setup cycle, then access cycle until pready
	task automatic apb_access(bit write, logic [2:0] slot, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {slot, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// offer one request and hold it until the block takes it
	task automatic send_byte(logic [7:0] data, bit first);
		if (req_idle_on && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data_byte <= data;
		req.first_of_message <= first;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		bytes_sent++;
	endtask

	// stop offering and wait for every outstanding response
	task automatic drain_requests();
		req.valid <= 1'b0;
		@(posedge clk);
		while (bytes_in_flight != 0) @(posedge clk);
	endtask

	// message of random bytes; with noise an odd byte restarts the stream
	task automatic send_message(int len, bit mark_first, bit noise);
		for (int i = 0; i < len; i++) begin
			// quiet tail, no idling on either side
			if (RANDOM_BYTES - (bytes_sent - random_start) < CALM_TAIL_BYTES) begin
				req_idle_on = 1'b0;
				rsp_idle_on = 1'b0;
			end
			send_byte(8'($urandom_range(0, 255)),
				(i == 0) ? mark_first : (noise && $urandom_range(0, 39) == 0));
		end
	endtask

	// value for a register: zero, all ones or random, counters often near the wrap
	function automatic logic [63:0] config_value(int style, int slot);
		if (slot == REG_START && $urandom_range(0, 3) == 0)
			return {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 1))};
		case (style)
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic read_back_all();
		for (int s = REG_KEY0; s <= REG_START; s++)
			apb_access(1'b0, 3'(s), '0);
	endtask

	initial begin
		int style;
		int msgs;
		int len;
		bit continuing;

		req.valid = 1'b0;
		req.data_byte = '0;
		req.first_of_message = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no first mark after reset: zero key, counter 0, position 0
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		drain_requests();

		// known-answer setup: key bytes 0..31, nonce ...4a..., counter 1
		apb_access(1'b1, REG_KEY0, 64'h0706_0504_0302_0100);
		apb_access(1'b1, REG_KEY1, 64'h0f0e_0d0c_0b0a_0908);
		apb_access(1'b1, REG_KEY2, 64'h1716_1514_1312_1110);
		apb_access(1'b1, REG_KEY3, 64'h1f1e_1d1c_1b1a_1918);
		apb_access(1'b1, REG_NONCE_LO, 64'h4a00_0000_0000_0000);
		apb_access(1'b1, REG_NONCE_HI, 64'h0);
		apb_access(1'b1, REG_START, 64'h1);
		// write past the map must leave every register alone
		apb_access(1'b1, UNUSED_SLOT, '1);
		read_back_all();

		// data extremes and single bits, then a restart mid-stream
		send_byte(8'h4c, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'hAA, 1'b0);
		drain_requests();

		// all-ones registers, upper bits of the narrow ones included
		for (int s = REG_KEY0; s <= REG_START; s++)
			apb_access(1'b1, 3'(s), '1);
		read_back_all();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h3C, 1'b1);
		send_byte(8'hC3, 1'b0);
		drain_requests();

		// counter wrap: start at the top, run across three blocks
		random_start = bytes_sent;
		apb_access(1'b1, REG_START, 64'hFFFF_FFFF);
		send_message(140, 1'b1, 1'b0);

		while (bytes_sent - random_start < RANDOM_BYTES) begin
			drain_requests();
			if (RANDOM_BYTES - (bytes_sent - random_start) < CALM_TAIL_BYTES) begin
				req_idle_on = 1'b0;
				rsp_idle_on = 1'b0;
			end else begin
				req_idle_on = ($urandom_range(0, 3) != 0);
				rsp_idle_on = ($urandom_range(0, 3) != 0);
			end

			// either a full new setting or one register changed mid-message
			style = $urandom_range(0, 5);
			continuing = ($urandom_range(0, 3) == 0);
			if (continuing) begin
				int slot;
				slot = $urandom_range(REG_KEY0, REG_START);
				apb_access(1'b1, 3'(slot), config_value(style, slot));
			end else begin
				for (int s = REG_KEY0; s <= REG_START; s++)
					apb_access(1'b1, 3'(s), config_value(style, s));
			end
			if ($urandom_range(0, 3) == 0)
				apb_access(1'b0, 3'($urandom_range(REG_KEY0, REG_START)), '0);

			msgs = $urandom_range(1, 4);
			for (int m = 0; m < msgs; m++) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
					: $urandom_range(20, 200);
				// keep the total close to the planned byte count
				if (len > RANDOM_BYTES - (bytes_sent - random_start))
					len = RANDOM_BYTES - (bytes_sent - random_start);
				if (len > 0)
					send_message(len, !(continuing && m == 0), $urandom_range(0, 7) == 0);
			end
		end

		drain_requests();
		repeat (2 * BLOCK_MAKE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/cc20_pkg.sv
src/cc20_if.sv
src/cc20_core.sv
src/chacha20_stream_cipher_unit.sv
tb/chacha20_stream_checker.sv
tb/chacha20_stream_cipher_unit_tb.sv
